>>> src/srf_pkg.sv
// Shared types and operation codes for the substring removal filter.
`timescale 1ns / 1ps

package srf_pkg;

	localparam int CODE_W = 21;
	localparam int OP_W   = 2;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [OP_W-1:0]   op_t;

	localparam op_t OP_PATTERN = 2'd0;
	localparam op_t OP_TEXT    = 2'd1;
	localparam op_t OP_END     = 2'd2;

	// Commands to the pattern store
	typedef struct packed {
		logic wr;
		logic clr;
	} pat_cmd_t;

	// Commands to the text window
	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} win_cmd_t;

endpackage

>>> src/substring_removal_filter_unit.sv
// Top level of the substring removal filter.
//
// Input channel (in_valid/in_stall): operation and code. Pattern codes come
// first and are stored; text codes follow; an end transaction closes the text.
// Output channel (out_valid/out_stall): code_res, has_code, last, status.
// Every occurrence of the pattern is removed, leftmost first, no overlap.
//
// A transaction is held in an input register while it is processed, and
// its result is loaded into the output register. Text streams at one code
// per cycle while the output is not stalled. An end transaction shifts each
// code still in the window out through the output register (or gives one
// empty marker if none is left); it then returns the block to its reset
// state, ready for a new pattern. A pattern longer than MAX_PATTERN makes
// the text give no codes and the end give one marker with status set.
// Reset clears all control state; the pattern and window stores need none.
// When out_stall is high a valid result in the output register holds and,
// once the pending transaction needs the register, in_stall rises; nothing is lost.
`timescale 1ns / 1ps

module substring_removal_filter_unit #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  srf_pkg::op_t         operation,
	input  srf_pkg::code_t       code,
	output logic                 out_valid,
	input  logic                 out_stall,
	output srf_pkg::code_t       code_res,
	output logic                 has_code,
	output logic                 last,
	output logic                 status
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic              valid_s1;
	srf_pkg::op_t      op_s1;
	srf_pkg::code_t    code_s1;
	logic              text_started_q;

	logic              out_valid_q;
	srf_pkg::code_t    code_res_q;
	logic              has_code_q;
	logic              last_q;
	logic              status_q;

	srf_pkg::pat_cmd_t pcmd;
	srf_pkg::win_cmd_t wcmd;
	srf_pkg::code_t    pat [MAX_PATTERN];
	logic [CNT_W-1:0]  pat_count;
	logic              overflow;
	logic [CNT_W-1:0]  win_count;
	srf_pkg::code_t    head;
	logic              full_hit;
	logic              match;

	logic              out_free;
	logic              done;
	logic              end_done;
	logic              emit;
	srf_pkg::code_t    emit_code;
	logic              emit_has;
	logic              emit_last;
	logic              emit_status;
	logic              accept;

	srf_pattern #(
		.MAX_PATTERN(MAX_PATTERN),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_pattern (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (pcmd),
		.code     (code_s1),
		.pat      (pat),
		.pat_count(pat_count),
		.overflow (overflow)
	);

	srf_window #(
		.MAX_PATTERN(MAX_PATTERN),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (wcmd),
		.code     (code_s1),
		.pat      (pat),
		.pat_count(pat_count),
		.win_count(win_count),
		.head     (head),
		.full_hit (full_hit),
		.match    (match)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !done;
	assign accept   = in_valid && !in_stall;

	// Decode the held transaction into store commands and a result
	always_comb begin
		done        = 1'b1;
		end_done    = 1'b0;
		emit        = 1'b0;
		emit_code   = '0;
		emit_has    = 1'b0;
		emit_last   = 1'b0;
		emit_status = 1'b0;
		pcmd        = '0;
		wcmd        = '0;
		if (valid_s1) begin
			unique case (op_s1)
				srf_pkg::OP_PATTERN: begin
					pcmd.wr = !text_started_q;
				end
				srf_pkg::OP_TEXT: begin
					if (!overflow) begin
						if (pat_count == '0) begin
							emit      = 1'b1;
							emit_code = code_s1;
							emit_has  = 1'b1;
							done      = out_free;
						end else begin
							emit      = full_hit && !match;
							emit_code = head;
							emit_has  = 1'b1;
							done      = !emit || out_free;
							wcmd.push = done;
						end
					end
				end
				srf_pkg::OP_END: begin
					emit      = 1'b1;
					emit_last = 1'b1;
					if (overflow || win_count == '0) begin
						emit_status = overflow;
						done        = out_free;
					end else begin
						emit_code = head;
						emit_has  = 1'b1;
						emit_last = win_count == CNT_W'(1);
						wcmd.pop  = out_free;
						done      = out_free && emit_last;
					end
					end_done = done;
					pcmd.clr = done;
					wcmd.clr = done;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the transaction under work in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			code_s1 <= code;
		end
	end

	// Mark text as started; drop back at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_started_q <= 1'b0;
		end else if (end_done) begin
			text_started_q <= 1'b0;
		end else if (valid_s1 && op_s1 == srf_pkg::OP_TEXT && done) begin
			text_started_q <= 1'b1;
		end
	end

	// Load the output register, or drain it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			code_res_q <= emit_code;
			has_code_q <= emit_has;
			last_q     <= emit_last;
			status_q   <= emit_status;
		end
	end

	assign out_valid = out_valid_q;
	assign code_res  = code_res_q;
	assign has_code  = has_code_q;
	assign last      = last_q;
	assign status    = status_q;

	// The window never reaches the pattern length
	a_win_below_pat: assert property (@(posedge clk) disable iff (!arst_n)
		win_count == '0 || win_count < pat_count)
		else $error("window count reached pattern count");

	// Overflow only with a full pattern store
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow |-> pat_count == CNT_W'(MAX_PATTERN))
		else $error("overflow with room in pattern store");

	// An empty marker always closes the string
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_code |-> last)
		else $error("empty marker without last");

	// Error status only on an empty end marker
	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !has_code && last)
		else $error("error status on a code result");

	// Stall input only while a transaction is under work
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with nothing held");

endmodule

>>> src/srf_pattern.sv
// Pattern store with fill count and overflow flag.
`timescale 1ns / 1ps

module srf_pattern #(
	parameter int MAX_PATTERN = 16,
	parameter int CNT_W       = 5,
	parameter int IDX_W       = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srf_pkg::pat_cmd_t     cmd,
	input  srf_pkg::code_t        code,
	output srf_pkg::code_t        pat [MAX_PATTERN],
	output logic [CNT_W-1:0]      pat_count,
	output logic                  overflow
);

	srf_pkg::code_t   pat_q [MAX_PATTERN];
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             has_room;

	assign has_room = count_q < CNT_W'(MAX_PATTERN);

	// Advance the fill count, or flag overflow when the store is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.clr) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.wr) begin
			if (has_room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	// Write the next pattern code
	always_ff @(posedge clk) begin
		if (cmd.wr && has_room && !cmd.clr) begin
			pat_q[count_q[IDX_W-1:0]] <= code;
		end
	end

	assign pat       = pat_q;
	assign pat_count = count_q;
	assign overflow  = overflow_q;

endmodule

>>> src/srf_window.sv
// Text window: pending codes, parallel compare against the pattern, shift out.
`timescale 1ns / 1ps

module srf_window #(
	parameter int MAX_PATTERN = 16,
	parameter int CNT_W       = 5,
	parameter int IDX_W       = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srf_pkg::win_cmd_t     cmd,
	input  srf_pkg::code_t        code,
	input  srf_pkg::code_t        pat [MAX_PATTERN],
	input  logic [CNT_W-1:0]      pat_count,
	output logic [CNT_W-1:0]      win_count,
	output srf_pkg::code_t        head,
	output logic                  full_hit,
	output logic                  match
);

	srf_pkg::code_t   win_q [MAX_PATTERN];
	srf_pkg::code_t   wnew  [MAX_PATTERN];
	logic [CNT_W-1:0] count_q;

	// Window as it stands with the incoming code placed after the pending ones
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			wnew[i] = (CNT_W'(i) == count_q) ? code : win_q[i];
		end
	end

	assign full_hit = (count_q + CNT_W'(1)) == pat_count;

	// Compare the filled window with the pattern, entry by entry
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (CNT_W'(i) < pat_count && wnew[i] != pat[i]) begin
				match = 1'b0;
			end
		end
	end

	assign head      = wnew[0];
	assign win_count = count_q;

	// Track the number of pending codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
		end else if (cmd.push) begin
			if (!full_hit) begin
				count_q <= count_q + CNT_W'(1);
			end else if (match) begin
				count_q <= '0;
			end
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Append, or drop the oldest code and shift the rest down
	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.clr) begin
			if (!full_hit) begin
				win_q[count_q[IDX_W-1:0]] <= code;
			end else if (!match) begin
				for (int i = 0; i < MAX_PATTERN - 1; i++) begin
					win_q[i] <= wnew[i+1];
				end
			end
		end else if (cmd.pop && !cmd.clr) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end
	end

endmodule

>>> sim/substring_removal_filter_checker.sv
// Checker for the substring removal filter: predicts each result and compares it.
`timescale 1ns / 1ps

module substring_removal_filter_checker #(
	parameter int MAX_PATTERN = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  srf_pkg::op_t   operation,
	input  srf_pkg::code_t code,
	input  logic           out_valid,
	input  logic           out_stall,
	input  srf_pkg::code_t code_res,
	input  logic           has_code,
	input  logic           last,
	input  logic           status,
	output int             errors,
	output int             checked,
	output int             pending
);

	typedef struct packed {
		srf_pkg::code_t code_res;
		logic           has_code;
		logic           last;
		logic           status;
	} kept_code_t;

	// Predicted filter state; the stores are only read where written
	srf_pkg::code_t pat_codes [MAX_PATTERN];
	int             pat_len;
	logic           pat_over;
	logic           text_seen;
	srf_pkg::code_t win_codes [MAX_PATTERN];
	int             win_len;

	kept_code_t kept_q[$];

	task clear_filter();
		pat_len   = 0;
		pat_over  = 1'b0;
		text_seen = 1'b0;
		win_len   = 0;
	endtask

	task push_kept(input srf_pkg::code_t c, input logic h, input logic l, input logic s);
		kept_code_t r;
		r.code_res = c;
		r.has_code = h;
		r.last     = l;
		r.status   = s;
		kept_q.push_back(r);
	endtask

	// Advance the predicted filter by one accepted transaction
	task predict_removal(input srf_pkg::op_t op, input srf_pkg::code_t c);
		int   i;
		logic same;
		case (op)
			srf_pkg::OP_PATTERN: begin
				if (!text_seen) begin
					if (pat_len < MAX_PATTERN) begin
						pat_codes[pat_len] = c;
						pat_len++;
					end else begin
						pat_over = 1'b1;
					end
				end
			end
			srf_pkg::OP_TEXT: begin
				text_seen = 1'b1;
				if (!pat_over) begin
					if (pat_len == 0) begin
						push_kept(c, 1'b1, 1'b0, 1'b0);
					end else begin
						if (win_len < MAX_PATTERN) begin
							win_codes[win_len] = c;
							win_len++;
						end
						// Full window: drop it on a match, else emit the oldest code
						if (win_len >= pat_len) begin
							same = 1'b1;
							for (i = 0; i < pat_len; i++)
								if (win_codes[i] != pat_codes[i])
									same = 1'b0;
							if (same) begin
								win_len = 0;
							end else begin
								push_kept(win_codes[0], 1'b1, 1'b0, 1'b0);
								for (i = 1; i < win_len; i++)
									win_codes[i-1] = win_codes[i];
								win_len--;
							end
						end
					end
				end
			end
			srf_pkg::OP_END: begin
				if (pat_over) begin
					push_kept('0, 1'b0, 1'b1, 1'b1);
				end else if (win_len == 0) begin
					push_kept('0, 1'b0, 1'b1, 1'b0);
				end else begin
					for (i = 0; i < win_len; i++)
						push_kept(win_codes[i], 1'b1, (i == win_len - 1), 1'b0);
				end
				clear_filter();
			end
			default: begin
				// unused operation: no effect
			end
		endcase
	endtask

	// Compare one accepted result with the oldest prediction
	task compare_kept();
		kept_code_t want;
		if (kept_q.size() == 0) begin
			$error("unexpected result: code_res %0h has_code %0b last %0b status %0b",
				code_res, has_code, last, status);
			errors++;
		end else begin
			want = kept_q.pop_front();
			checked++;
			if (code_res !== want.code_res) begin
				$error("code_res mismatch: expected %0h, got %0h", want.code_res, code_res);
				errors++;
			end
			if (has_code !== want.has_code) begin
				$error("has_code mismatch: expected %0b, got %0b", want.has_code, has_code);
				errors++;
			end
			if (last !== want.last) begin
				$error("last mismatch: expected %0b, got %0b", want.last, last);
				errors++;
			end
			if (status !== want.status) begin
				$error("status mismatch: expected %0b, got %0b", want.status, status);
				errors++;
			end
		end
	endtask

	// Watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_filter();
			kept_q.delete();
			errors  = 0;
			checked = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_removal(operation, code);
			if (out_valid && !out_stall)
				compare_kept();
		end
		pending = kept_q.size();
	end

endmodule

>>> sim/substring_removal_filter_unit_tb.sv
// Testbench top for the substring removal filter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module substring_removal_filter_unit_tb;

	localparam int             MAX_PATTERN  = 16;
	localparam srf_pkg::op_t   OP_UNUSED    = 2'd3;
	localparam srf_pkg::code_t CODE_MAX     = 21'h10FFFF;
	localparam int             RANDOM_ITEMS = 128;
	localparam int             HOLD_CYCLES  = 64;
	localparam int             QUIET_LIMIT  = 2000;
	localparam int             DRAIN_CYCLES = 24;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	srf_pkg::op_t   operation;
	srf_pkg::code_t code;
	logic           out_valid;
	logic           out_stall;
	srf_pkg::code_t code_res;
	logic           has_code;
	logic           last;
	logic           status;

	int errors;
	int checked;
	int pending;

	int send_idle_pct;
	int recv_stall_pct;
	int noise_pct;
	bit hold_req;
	int hold_left;
	int items_sent;
	int strings_sent;
	int overflow_strings;
	int quiet_cycles;

	substring_removal_filter_unit #(
		.MAX_PATTERN(MAX_PATTERN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.code(code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_res(code_res),
		.has_code(has_code),
		.last(last),
		.status(status)
	);

	substring_removal_filter_checker #(
		.MAX_PATTERN(MAX_PATTERN)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.code(code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_res(code_res),
		.has_code(has_code),
		.last(last),
		.status(status),
		.errors(errors),
		.checked(checked),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, pending);
			$display("substring_removal_filter_unit_tb: errors");
			$finish;
		end
	end

	// Offer one transaction and hold it until accepted; starts and ends at a falling edge
	task automatic send_item(input srf_pkg::op_t op, input srf_pkg::code_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		code      <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_string(input srf_pkg::code_t pat[$], input srf_pkg::code_t txt[$],
		input bit close);
		foreach (pat[k])
			send_item(srf_pkg::OP_PATTERN, pat[k]);
		foreach (txt[k]) begin
			send_item(srf_pkg::OP_TEXT, txt[k]);
			// inject an ignored transaction now and then
			if ($urandom_range(0, 99) < noise_pct)
				send_item($urandom_range(0, 1) ? OP_UNUSED : srf_pkg::OP_PATTERN,
					srf_pkg::code_t'($urandom_range(0, CODE_MAX)));
		end
		if (close)
			send_item(srf_pkg::OP_END, srf_pkg::code_t'($urandom_range(0, CODE_MAX)));
		strings_sent++;
		if (pat.size() > MAX_PATTERN)
			overflow_strings++;
	endtask

	// Build a pattern and a text over a tiny alphabet so that matches are frequent
	task automatic random_string();
		srf_pkg::code_t alpha [4];
		srf_pkg::code_t pat[$];
		srf_pkg::code_t txt[$];
		int             plen;
		int             tlen;
		int             pick;
		foreach (alpha[k])
			alpha[k] = srf_pkg::code_t'($urandom_range(0, CODE_MAX));
		pick = $urandom_range(0, 99);
		if (pick < 8)
			plen = 0;
		else if (pick < 14)
			plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 2);
		else if (pick < 20)
			plen = $urandom_range(5, MAX_PATTERN);
		else
			plen = $urandom_range(1, 4);
		for (int k = 0; k < plen; k++)
			pat.push_back(alpha[$urandom_range(0, 1)]);
		tlen = $urandom_range(0, 12);
		while (txt.size() < tlen) begin
			pick = $urandom_range(0, 99);
			if (pick < 35 && plen > 0 && plen <= MAX_PATTERN) begin
				foreach (pat[k])
					txt.push_back(pat[k]);
				// near miss: spoil the final code
				if (pick < 5)
					txt[txt.size() - 1] = alpha[2];
			end else if (pick < 90) begin
				txt.push_back(alpha[$urandom_range(0, 1)]);
			end else begin
				txt.push_back(srf_pkg::code_t'($urandom_range(0, CODE_MAX)));
			end
		end
		// an unclosed string merges into the next one
		send_string(pat, txt, $urandom_range(0, 99) >= 8);
	endtask

	initial begin
		int base;
		int phase;
		bit hold_done;

		arst_n           = 1'b0;
		in_valid         = 1'b0;
		operation        = srf_pkg::OP_PATTERN;
		code             = '0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		noise_pct        = 0;
		hold_req         = 1'b0;
		hold_done        = 1'b0;
		items_sent       = 0;
		strings_sent     = 0;
		overflow_strings = 0;
		quiet_cycles     = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty pattern: text passes through, largest code, unused operation
		send_item(srf_pkg::OP_TEXT, CODE_MAX);
		send_item(OP_UNUSED, '0);
		send_item(srf_pkg::OP_END, CODE_MAX);

		// Single-code pattern: keep b, remove a, ignore a late pattern code, empty tail
		send_item(srf_pkg::OP_PATTERN, 21'h61);
		send_item(srf_pkg::OP_TEXT, 21'h62);
		send_item(srf_pkg::OP_TEXT, 21'h61);
		send_item(srf_pkg::OP_PATTERN, 21'h7A);
		send_item(srf_pkg::OP_END, '0);

		// Pattern longer than the store: text dropped, end reports the error
		for (int k = 0; k <= MAX_PATTERN; k++)
			send_item(srf_pkg::OP_PATTERN,
				(k == 0) ? srf_pkg::code_t'(0) : srf_pkg::code_t'(CODE_MAX - k));
		send_item(srf_pkg::OP_TEXT, 21'h41);
		send_item(srf_pkg::OP_END, '0);
		strings_sent     = 3;
		overflow_strings = 1;

		// Random strings, cycling through the idling phases
		noise_pct = 5;
		base      = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			phase = ((items_sent - base) / (RANDOM_ITEMS / 4)) % 4;
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 52;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 52;
				end
				default: begin
					send_idle_pct  = 17;
					recv_stall_pct = 17;
				end
			endcase
			// fill the block while the receiver holds off
			if (!hold_done && items_sent - base >= 20) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			random_string();
		end
		send_item(srf_pkg::OP_END, '0);
		in_valid       <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		// Drain outstanding results, then allow for any trailing output
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions in %0d strings (%0d with an oversized pattern).",
			items_sent, strings_sent, overflow_strings);
		$display("Checked %0d results under every idling mix, with one long output hold-off.",
			checked);
		if (errors == 0)
			$display("substring_removal_filter_unit_tb: clean");
		else
			$display("substring_removal_filter_unit_tb: errors");
		$finish;
	end

endmodule
